/* rtl/core/signed_binary_to_ascii_decimal_defines.svh */
// Assertion macros used by the converter checker.
`ifndef SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH
`define SIGNED_BINARY_TO_ASCII_DECIMAL_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define SBAD_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sbad check failed");

// Property checked on every clock edge, reset included.
`define SBAD_CHECK_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("sbad reset check failed");

`endif

/* rtl/core/sbad_pkg.sv */
// Shared types, constants and the shift-and-add-3 step for the converter.
package sbad_pkg;

  localparam int MAG_W         = 24;
  localparam int BCD_W         = 32;
  localparam int BITS_PER_STEP = 3;
  localparam int N_STEPS       = MAG_W / BITS_PER_STEP;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] NDIG_16  = 4'd5;
  localparam logic [3:0] NDIG_S24 = 4'd7;
  localparam logic [3:0] NDIG_U24 = 4'd8;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [3:0]       ndig;
  } job_t;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic             neg;
    logic [3:0]       ndig;
  } res_t;

  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                    input logic b);
    logic [BCD_W-1:0] adj;
    for (int d = 0; d < BCD_W / 4; d++) begin
      adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3 : bcd[4*d +: 4];
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

/* rtl/core/sbad_classify.sv */
// Front end: sign test, negation within width and digit count for one item.
module sbad_classify (
  input  logic [23:0]  value,
  input  logic         wide_mode,
  input  logic         is_signed,
  output sbad_pkg::job_t job
);
  import sbad_pkg::*;

  logic [MAG_W-1:0] raw;
  logic [MAG_W-1:0] negr;
  logic             neg;

  always_comb begin
    raw  = wide_mode ? value : {8'b0, value[15:0]};
    neg  = is_signed && (wide_mode ? value[23] : value[15]);
    negr = MAG_W'(~raw + 24'd1);
    job.neg = neg;
    if (neg) begin
      job.mag = wide_mode ? negr : {8'b0, negr[15:0]};
    end else begin
      job.mag = raw;
    end
    if (wide_mode) begin
      job.ndig = is_signed ? NDIG_S24 : NDIG_U24;
    end else begin
      job.ndig = NDIG_16;
    end
  end

endmodule

/* rtl/core/sbad_queue.sv */
// Two-entry queue between the front end and the conversion back end.
module sbad_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           full,
  input  sbad_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_take,
  output sbad_pkg::job_t rd_data
);
  import sbad_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign push     = wr_valid && !full;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

endmodule

/* rtl/core/sbad_convert.sv */
// Iterative double dabble (three bits per unstalled cycle) with a result register.
module sbad_convert (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_take,
  input  sbad_pkg::job_t job,
  output logic           done_valid,
  input  logic           done_take,
  output sbad_pkg::res_t done
);
  import sbad_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'(N_STEPS - 1);

  logic             busy;
  logic [2:0]       cnt;
  logic [MAG_W-1:0] mag_sh;
  logic [BCD_W-1:0] bcd_w;
  logic             neg_w;
  logic [3:0]       ndig_w;
  logic [BCD_W-1:0] bcd_next;
  logic             final_step;
  logic             can_step;

  assign bcd_next   = dabble_step(dabble_step(dabble_step(bcd_w, mag_sh[MAG_W-1]),
                                              mag_sh[MAG_W-2]), mag_sh[MAG_W-3]);
  assign final_step = busy && (cnt == STEP_LAST);
  assign can_step   = busy && (!final_step || !done_valid || done_take);
  assign job_take   = !busy && job_valid;

  always_ff @(posedge clk) begin
    if (job_take) begin
      mag_sh <= job.mag;
      bcd_w  <= '0;
      neg_w  <= job.neg;
      ndig_w <= job.ndig;
    end else if (can_step) begin
      mag_sh <= {mag_sh[MAG_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
      bcd_w  <= bcd_next;
    end
    if (can_step && final_step) begin
      done.bcd  <= bcd_next;
      done.neg  <= neg_w;
      done.ndig <= ndig_w;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      cnt        <= 3'd0;
      done_valid <= 1'b0;
    end else begin
      if (job_take) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (can_step) begin
        cnt <= 3'(cnt + 3'd1);
        if (final_step) begin
          busy <= 1'b0;
        end
      end
      if (can_step && final_step) begin
        done_valid <= 1'b1;
      end else if (done_take) begin
        done_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/sbad_emit.sv */
// Back end serializer: sign then digits, one character per transaction.
module sbad_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           done_valid,
  output logic           done_take,
  input  sbad_pkg::res_t done,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     character,
  output logic           last
);
  import sbad_pkg::*;

  logic             active;
  logic             sign_pending;
  logic [3:0]       remain;
  logic [BCD_W-1:0] bcd;
  logic             neg;
  logic             adv;
  logic             final_digit;
  logic [2:0]       dig_idx;
  logic [3:0]       digit;

  assign adv         = !out_valid || !out_stall;
  assign final_digit = active && !sign_pending && (remain == 4'd1);
  assign done_take   = done_valid && (!active || (adv && final_digit));
  assign dig_idx     = 3'(remain - 4'd1);
  assign digit       = bcd[4*dig_idx +: 4];

  always_ff @(posedge clk) begin
    if (done_take) begin
      bcd <= done.bcd;
      neg <= done.neg;
    end
    if (adv && active) begin
      if (sign_pending) begin
        character <= neg ? CHAR_MINUS : CHAR_PLUS;
        last      <= 1'b0;
      end else begin
        character <= CHAR_ZERO + {4'b0, digit};
        last      <= (remain == 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      sign_pending <= 1'b0;
      remain       <= 4'd0;
      out_valid    <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= active;
      end
      if (done_take) begin
        active       <= 1'b1;
        sign_pending <= 1'b1;
        remain       <= done.ndig;
      end else if (adv && active) begin
        if (sign_pending) begin
          sign_pending <= 1'b0;
        end else begin
          remain <= 4'(remain - 4'd1);
          if (remain == 4'd1) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

/* rtl/core/signed_binary_to_ascii_decimal.sv */
// Top level: signed or unsigned 16/24-bit binary to an ASCII decimal string.
// Each accepted value yields a '+' or '-' sign character followed by its
// digits, most significant first with leading zeros: 5 digits in 16-bit mode,
// 7 in signed 24-bit mode, 8 in unsigned 24-bit mode; last marks the final
// digit. The double-dabble unit converts a value in a load and eight steps
// of three bits, and can take the next value while the previous string is
// still being sent. The output port sends one character per cycle while
// out_stall is low. A two-entry queue after the front end absorbs input
// while the back end is busy.
module signed_binary_to_ascii_decimal (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] value,
  input  logic        wide_mode,
  input  logic        is_signed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last
);
  import sbad_pkg::*;

  job_t job_in;
  job_t job_q;
  res_t res;
  logic q_full;
  logic q_valid;
  logic q_take;
  logic res_valid;
  logic res_take;

  assign in_stall = q_full;

  sbad_classify u_classify (
    .value     (value),
    .wide_mode (wide_mode),
    .is_signed (is_signed),
    .job       (job_in)
  );

  sbad_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (in_valid),
    .full     (q_full),
    .wr_data  (job_in),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (job_q)
  );

  sbad_convert u_convert (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_take   (q_take),
    .job        (job_q),
    .done_valid (res_valid),
    .done_take  (res_take),
    .done       (res)
  );

  sbad_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .done_valid (res_valid),
    .done_take  (res_take),
    .done       (res),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last)
  );

endmodule

/* rtl/core/sbad_checker.sv */
// Port-level checks for the converter, bound to the top level.
`include "signed_binary_to_ascii_decimal_defines.svh"

module sbad_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] character,
  input logic       last
);
  import sbad_pkg::*;

  logic is_digit;
  logic is_sign;

  assign is_digit = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign is_sign  = (character == CHAR_PLUS) || (character == CHAR_MINUS);

  `SBAD_CHECK_RST(a_reset_idle, rst |=> !out_valid)
  `SBAD_CHECK(a_stall_hold, out_valid && out_stall |=> out_valid && $stable({character, last}))
  `SBAD_CHECK(a_last_digit, out_valid && last |-> is_digit)
  `SBAD_CHECK(a_legal_char, out_valid |-> is_digit || is_sign)
  `SBAD_CHECK(a_stall_known, !$isunknown(in_stall))

endmodule

bind signed_binary_to_ascii_decimal sbad_checker u_sbad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .character (character),
  .last      (last)
);
